FILE: rtl/u16u8_pkg.sv
// u16u8_pkg: shared types, constants and utf-8 encoding helpers
// used by the front, queue and back of the utf-16 to utf-8 transcoder
// no dependencies
package u16u8_pkg;

    localparam logic [15:0] RESET_REPLACEMENT = 16'hFFFD;
    localparam int          QUEUE_DEPTH       = 4;
    localparam int          QUEUE_PTR_BITS    = 2;

    localparam logic [5:0]  LEAD_TAG          = 6'b110110;
    localparam logic [5:0]  TRAIL_TAG         = 6'b110111;

    // one unit's worth of work: one or two code points plus status
    typedef struct packed {
        logic [20:0] cp0;
        logic [15:0] cp1;
        logic        has1;
        logic        last;
        logic        inv;
        logic [15:0] first_idx;
    } job_t;

    // queue to back handshake
    typedef struct packed {
        logic valid;
        job_t job;
    } job_beat_t;

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80)
        begin
            n = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            n = 3'd2;
        end
        else if (cp < 21'h10000)
        begin
            n = 3'd3;
        end
        else
        begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp, input logic [1:0] pos);
        logic [7:0] b;
        logic [2:0] n;
        n = utf8_len(cp);
        b = {2'b10, cp[5:0]};
        unique case (n)
            3'd1:
            begin
                b = {1'b0, cp[6:0]};
            end
            3'd2:
            begin
                if (pos == 2'd0)
                begin
                    b = {3'b110, cp[10:6]};
                end
            end
            3'd3:
            begin
                if (pos == 2'd0)
                begin
                    b = {4'b1110, cp[15:12]};
                end
                else if (pos == 2'd1)
                begin
                    b = {2'b10, cp[11:6]};
                end
            end
            default:
            begin
                if (pos == 2'd0)
                begin
                    b = {5'b11110, cp[20:18]};
                end
                else if (pos == 2'd1)
                begin
                    b = {2'b10, cp[17:12]};
                end
                else if (pos == 2'd2)
                begin
                    b = {2'b10, cp[11:6]};
                end
            end
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/u16u8_front.sv
// u16u8_front: classifies utf-16 units, pairs surrogates, tracks string index
// and first invalid position, builds jobs for the queue; uses u16u8_pkg
module u16u8_front
    import u16u8_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output logic        push,
    output job_t        job
);

    logic [15:0]           repl_reg;
    logic [9:0]            lead_bits_reg;
    logic                  lead_valid_reg;
    logic [15:0]           lead_idx_reg;
    logic [INDEX_BITS-1:0] unit_index_reg;
    logic                  inv_reg;
    logic [15:0]           bad_idx_reg;

    logic [9:0]            lead_bits_next;
    logic                  lead_valid_next;
    logic [15:0]           lead_idx_next;
    logic [INDEX_BITS-1:0] unit_index_next;
    logic                  inv_next;
    logic [15:0]           bad_idx_next;

    logic [INDEX_BITS+15:0] idx_ext;
    logic [15:0]            idx16;
    logic                   is_lead;
    logic                   is_trail;
    logic                   mark_lead;
    logic                   mark_self;
    logic                   fresh;
    logic                   fresh_has;
    logic [15:0]            fresh_cp;
    logic                   has0;
    logic [20:0]            pair_cp;

    assign idx_ext  = {16'd0, unit_index_reg};
    assign idx16    = idx_ext[15:0];
    assign is_lead  = (code_unit[15:10] == LEAD_TAG);
    assign is_trail = (code_unit[15:10] == TRAIL_TAG);
    assign pair_cp  = 21'h10000 + {1'b0, lead_bits_reg, code_unit[9:0]};

    always_comb
    begin
        mark_lead       = 1'b0;
        mark_self       = 1'b0;
        fresh           = 1'b1;
        fresh_has       = 1'b1;
        fresh_cp        = code_unit;
        has0            = 1'b0;
        job.cp0         = 21'd0;
        job.cp1         = 16'd0;
        job.has1        = 1'b0;
        lead_bits_next  = lead_bits_reg;
        lead_valid_next = lead_valid_reg;
        lead_idx_next   = lead_idx_reg;

        if (lead_valid_reg)
        begin
            lead_valid_next = 1'b0;
            has0            = 1'b1;
            if (is_trail)
            begin
                job.cp0 = pair_cp;
                fresh   = 1'b0;
            end
            else
            begin
                // unpaired lead, reported at the lead's own index
                job.cp0   = {5'd0, repl_reg};
                mark_lead = 1'b1;
            end
        end

        if (fresh)
        begin
            if (is_lead)
            begin
                if (last_unit)
                begin
                    mark_self = 1'b1;
                    fresh_cp  = repl_reg;
                end
                else
                begin
                    fresh_has       = 1'b0;
                    lead_valid_next = 1'b1;
                    lead_bits_next  = code_unit[9:0];
                    lead_idx_next   = idx16;
                end
            end
            else if (is_trail)
            begin
                mark_self = 1'b1;
                fresh_cp  = repl_reg;
            end
        end
        else
        begin
            fresh_has = 1'b0;
        end

        if (has0)
        begin
            job.cp1  = fresh_cp;
            job.has1 = fresh_has;
        end
        else
        begin
            job.cp0 = {5'd0, fresh_cp};
            has0    = fresh_has;
        end

        inv_next = inv_reg | mark_lead | mark_self;
        if (inv_reg)
        begin
            bad_idx_next = bad_idx_reg;
        end
        else if (mark_lead)
        begin
            bad_idx_next = lead_idx_reg;
        end
        else if (mark_self)
        begin
            bad_idx_next = idx16;
        end
        else
        begin
            bad_idx_next = bad_idx_reg;
        end

        if (unit_index_reg != {INDEX_BITS{1'b1}})
        begin
            unit_index_next = unit_index_reg + INDEX_BITS'(1);
        end
        else
        begin
            unit_index_next = unit_index_reg;
        end

        job.last      = last_unit;
        job.inv       = inv_next;
        job.first_idx = bad_idx_next;
    end

    assign push = accept & has0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg       <= RESET_REPLACEMENT;
            lead_bits_reg  <= '0;
            lead_valid_reg <= 1'b0;
            lead_idx_reg   <= '0;
            unit_index_reg <= '0;
            inv_reg        <= 1'b0;
            bad_idx_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                repl_reg <= cfg_data;
            end
            if (accept)
            begin
                if (last_unit)
                begin
                    lead_bits_reg  <= '0;
                    lead_valid_reg <= 1'b0;
                    lead_idx_reg   <= '0;
                    unit_index_reg <= '0;
                    inv_reg        <= 1'b0;
                    bad_idx_reg    <= '0;
                end
                else
                begin
                    lead_bits_reg  <= lead_bits_next;
                    lead_valid_reg <= lead_valid_next;
                    lead_idx_reg   <= lead_idx_next;
                    unit_index_reg <= unit_index_next;
                    inv_reg        <= inv_next;
                    bad_idx_reg    <= bad_idx_next;
                end
            end
        end
    end

endmodule

FILE: rtl/u16u8_queue.sv
// u16u8_queue: small job fifo between front and back
// uses u16u8_pkg for job_t and depth constants
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output logic      full,
    output job_beat_t head
);

    job_t                    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic [QUEUE_PTR_BITS:0]   count_next;

    assign full       = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/u16u8_back.sv
// u16u8_back: walks one job's code points and sends one utf-8 byte per cycle
// while not stalled, via an output register; uses u16u8_pkg encoding helpers
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_beat_t   head,
    output logic        pop,
    input  logic        byte_stall,
    output logic        byte_valid,
    output logic [7:0]  utf8_byte,
    output logic        last_byte,
    output logic        invalid_seen,
    output logic [15:0] first_invalid_index
);

    job_t        job_reg;
    logic        job_valid_reg;
    logic        sel_reg;
    logic [1:0]  pos_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        inv_reg;
    logic [15:0] first_reg;

    logic [20:0] cur_cp;
    logic [2:0]  cur_len;
    logic [7:0]  cur_byte;
    logic        end_of_cp;
    logic        end_of_job;
    logic        advance;

    assign cur_cp     = sel_reg ? {5'd0, job_reg.cp1} : job_reg.cp0;
    assign cur_len    = utf8_len(cur_cp);
    assign cur_byte   = utf8_byte_at(cur_cp, pos_reg);
    assign end_of_cp  = ({1'b0, pos_reg} == (cur_len - 3'd1));
    assign end_of_job = end_of_cp & (sel_reg | ~job_reg.has1);
    assign advance    = job_valid_reg & (~out_valid_reg | ~byte_stall);
    assign pop        = head.valid & (~job_valid_reg | (advance & end_of_job));

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head.job;
        end
        if (advance)
        begin
            byte_reg  <= cur_byte;
            last_reg  <= job_reg.last & end_of_job;
            inv_reg   <= job_reg.inv;
            first_reg <= job_reg.first_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!byte_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (pop)
            begin
                job_valid_reg <= 1'b1;
                sel_reg       <= 1'b0;
                pos_reg       <= '0;
            end
            else if (advance)
            begin
                if (end_of_job)
                begin
                    job_valid_reg <= 1'b0;
                end
                else if (end_of_cp)
                begin
                    sel_reg <= 1'b1;
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    assign byte_valid          = out_valid_reg;
    assign utf8_byte           = byte_reg;
    assign last_byte           = last_reg;
    assign invalid_seen        = inv_reg;
    assign first_invalid_index = first_reg;

endmodule

FILE: rtl/utf16_to_utf8_lenient_transcoder.sv
// utf16_to_utf8_lenient_transcoder: top level, utf-16 units in, utf-8 bytes out
// instantiates u16u8_front, u16u8_queue and u16u8_back; uses u16u8_pkg
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------------
//  unit     | in        | unit_valid/unit_stall | code_unit, last_unit
//  byte     | out       | byte_valid/byte_stall | utf8_byte, last_byte, invalid_seen,
//           |           |                       | first_invalid_index
//  cfg      | in        | cfg_valid/cfg_ready   | cfg_data (replacement code point)
//
// the front takes one unit per cycle while the 4-deep job queue has room
// the output sends one byte per cycle while byte_stall is low, set by the single
//   byte-wide output register; a unit yields 0 to 6 bytes, 3 for a typical bmp unit above u+07ff
// first byte of a unit passes from the unit beat through a queue slot and the job register into the output register
// reset (rst_n low, async) empties queue and output, sets replacement to u+fffd
// byte_stall holds the output beat; the queue absorbs up to 4 jobs, then unit_stall rises
module utf16_to_utf8_lenient_transcoder
    import u16u8_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        unit_valid,
    output logic        unit_stall,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  utf8_byte,
    output logic        last_byte,
    output logic        invalid_seen,
    output logic [15:0] first_invalid_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic      unit_accept;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    job_t      front_job;
    job_beat_t q_head;

    // queue full is the only back-pressure on the unit side
    assign unit_stall  = q_full;
    assign unit_accept = unit_valid & ~unit_stall;
    assign cfg_ready   = 1'b1;

    u16u8_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (unit_accept),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .push      (q_push),
        .job       (front_job)
    );

    u16u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .full     (q_full),
        .head     (q_head)
    );

    u16u8_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head                (q_head),
        .pop                 (q_pop),
        .byte_stall          (byte_stall),
        .byte_valid          (byte_valid),
        .utf8_byte           (utf8_byte),
        .last_byte           (last_byte),
        .invalid_seen        (invalid_seen),
        .first_invalid_index (first_invalid_index)
    );

    // no job is written into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("job pushed into full queue");

    // back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && !q_head.valid))
        else $error("pop from empty queue");

    // the first invalid index reads zero until an invalid surrogate is seen
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !invalid_seen) |-> (first_invalid_index == 16'd0))
        else $error("first invalid index set without invalid flag");

endmodule

FILE: sim/utf8_stream_checker.sv
// utf8_stream_checker: watches the unit, byte and cfg channels of the transcoder,
// predicts the utf-8 beats of every accepted unit and compares them in order
// depends on u16u8_pkg for the surrogate tags and the reset replacement
`timescale 1ns / 100ps

module utf8_stream_checker
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        unit_valid,
    input  logic        unit_stall,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  utf8_byte,
    input  logic        last_byte,
    input  logic        invalid_seen,
    input  logic [15:0] first_invalid_index,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          beats_due
);

    typedef struct packed {
        logic [7:0]  data;
        logic        tail;
        logic        bad;
        logic [15:0] bad_at;
    } utf8_beat_t;

    utf8_beat_t  utf8_due[$];
    utf8_beat_t  want;
    logic [7:0]  step_bytes[$];

    // predicted transcoder state
    logic [15:0] repl_cp;
    logic [9:0]  held_lead;
    logic        lead_held;
    logic [15:0] lead_at;
    logic [15:0] unit_at;
    logic        bad_seen;
    logic [15:0] bad_at;

    initial
    begin
        fail_count = 0;
        beats_due  = 0;
    end

    // appends one byte to the current unit's byte list
    task automatic add_byte(input logic [7:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endtask

    task automatic emit_cp(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            add_byte({1'b0, cp[6:0]});
        end
        else if (cp < 21'h800)
        begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else
        begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic flag_bad(input logic [15:0] at);
        if (!bad_seen)
        begin
            bad_seen = 1'b1;
            bad_at   = at;
        end
        emit_cp({5'd0, repl_cp});
    endtask

    task automatic clear_string();
        held_lead = '0;
        lead_held = 1'b0;
        lead_at   = '0;
        unit_at   = '0;
        bad_seen  = 1'b0;
        bad_at    = '0;
    endtask

    task automatic predict_unit(input logic [15:0] cu, input logic fin);
        logic [15:0] here;
        logic        lead;
        logic        trail;
        logic        fresh;
        utf8_beat_t  beat;
        here  = unit_at;
        lead  = (cu[15:10] == LEAD_TAG);
        trail = (cu[15:10] == TRAIL_TAG);
        fresh = 1'b1;
        step_bytes.delete();
        if (unit_at != '1)
        begin
            unit_at = unit_at + 16'd1;
        end
        if (lead_held)
        begin
            lead_held = 1'b0;
            if (trail)
            begin
                emit_cp(21'h10000 + {1'b0, held_lead, cu[9:0]});
                fresh = 1'b0;
            end
            else
            begin
                flag_bad(lead_at);
            end
        end
        if (fresh)
        begin
            if (lead && !fin)
            begin
                lead_held = 1'b1;
                held_lead = cu[9:0];
                lead_at   = here;
            end
            else if (lead || trail)
            begin
                flag_bad(here);
            end
            else
            begin
                emit_cp({5'd0, cu});
            end
        end
        foreach (step_bytes[k])
        begin
            beat.data   = step_bytes[k];
            beat.tail   = fin && (k == step_bytes.size() - 1);
            beat.bad    = bad_seen;
            beat.bad_at = bad_seen ? bad_at : 16'd0;
            utf8_due.insert(utf8_due.size(), beat);
        end
        if (fin)
        begin
            clear_string();
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_cp = RESET_REPLACEMENT;
            clear_string();
            utf8_due.delete();
            beats_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                repl_cp = cfg_data;
            end
            if (unit_valid && !unit_stall)
            begin
                predict_unit(code_unit, last_unit);
            end
            if (byte_valid && !byte_stall)
            begin
                if (utf8_due.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual byte %h",
                             $time, utf8_byte);
                    fail_count++;
                end
                else
                begin
                    want = utf8_due.pop_front();
                    check_field("utf8_byte", want.data, utf8_byte);
                    check_field("last_byte", want.tail, last_byte);
                    check_field("invalid_seen", want.bad, invalid_seen);
                    check_field("first_invalid_index", want.bad_at, first_invalid_index);
                end
            end
            beats_due = utf8_due.size();
        end
    end

endmodule

FILE: sim/tb.sv
// tb: stimulus and verdict for utf16_to_utf8_lenient_transcoder
// depends on u16u8_pkg, the transcoder rtl and utf8_stream_checker
`timescale 1ns / 100ps

module tb;
    import u16u8_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_UNITS = 100;

    logic        clk;
    logic        rst_n;
    logic        unit_valid;
    logic        unit_stall;
    logic [15:0] code_unit;
    logic        last_unit;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  utf8_byte;
    logic        last_byte;
    logic        invalid_seen;
    logic [15:0] first_invalid_index;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          fail_count;
    int          beats_due;
    int          cycles;
    int          rx_hold;
    int          units_sent;
    int          strings_sent;
    logic        tx_calm;
    logic        rx_calm;
    logic [15:0] string_units[$];

    utf16_to_utf8_lenient_transcoder dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .unit_valid          (unit_valid),
        .unit_stall          (unit_stall),
        .code_unit           (code_unit),
        .last_unit           (last_unit),
        .byte_valid          (byte_valid),
        .byte_stall          (byte_stall),
        .utf8_byte           (utf8_byte),
        .last_byte           (last_byte),
        .invalid_seen        (invalid_seen),
        .first_invalid_index (first_invalid_index),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data)
    );

    utf8_stream_checker beat_check
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .unit_valid          (unit_valid),
        .unit_stall          (unit_stall),
        .code_unit           (code_unit),
        .last_unit           (last_unit),
        .byte_valid          (byte_valid),
        .byte_stall          (byte_stall),
        .utf8_byte           (utf8_byte),
        .last_byte           (last_byte),
        .invalid_seen        (invalid_seen),
        .first_invalid_index (first_invalid_index),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .fail_count          (fail_count),
        .beats_due           (beats_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run guard: a hung handshake ends the run here
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // sender gap: mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 9);
        if (tx_calm || r < 6)
        begin
            return 0;
        end
        else if (r < 9)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // byte side backpressure: random runs of open and stalled cycles
    initial
    begin
        byte_stall = 1'b0;
        rx_hold    = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
            end
            else if (rx_calm || $urandom_range(0, 2) != 0)
            begin
                byte_stall = 1'b0;
                rx_hold    = $urandom_range(0, 10);
            end
            else
            begin
                byte_stall = 1'b1;
                rx_hold    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end
        end
    end

    // one unit beat; valid stays high afterwards until a later gap or drain wait lowers it
    task automatic send_unit(input logic [15:0] cu, input logic fin);
        int gap;
        gap = tx_gap();
        repeat (gap)
        begin
            @(negedge clk);
            unit_valid = 1'b0;
        end
        @(negedge clk);
        unit_valid = 1'b1;
        code_unit  = cu;
        last_unit  = fin;
        @(posedge clk);
        while (unit_stall)
        begin
            @(posedge clk);
        end
        units_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        unit_valid = 1'b0;
        while (beats_due != 0)
        begin
            @(negedge clk);
        end
    endtask

    // sends the queued string, last_unit on its final unit; sometimes the sender
    // holds off, when pressure is set, until every expected beat is out
    task automatic send_string(input logic pressure);
        foreach (string_units[i])
        begin
            if (pressure && $urandom_range(0, 7) == 0)
            begin
                wait_drained();
            end
            send_unit(string_units[i], i == string_units.size() - 1);
        end
        string_units.delete();
        strings_sent++;
    endtask

    // only between strings: the last one has ended, so all its beats are known
    task automatic write_repl(input logic [15:0] cp);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = cp;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // bmp code point outside the surrogate range, spread over 1, 2 and 3 byte forms
    function automatic logic [15:0] plain_unit();
        logic [15:0] v;
        case ($urandom_range(0, 2))
            0:       v = 16'($urandom_range(16'h0000, 16'h007F));
            1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
            default:
            begin
                v = 16'($urandom_range(16'h0800, 16'hF7FF));
                if (v >= 16'hD800)
                begin
                    v = v + 16'h0800;
                end
            end
        endcase
        return v;
    endfunction

    // appends one unit to the string being built
    task automatic add_unit(input logic [15:0] cu);
        string_units.insert(string_units.size(), cu);
    endtask

    // mostly well-formed text with random content, some broken pairs and noise
    task automatic build_random_string();
        int pieces;
        int r;
        pieces = $urandom_range(1, 6);
        repeat (pieces)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
            begin
                add_unit(plain_unit());
            end
            else if (r < 8)
            begin
                add_unit({LEAD_TAG, 10'($urandom)});
                add_unit({TRAIL_TAG, 10'($urandom)});
            end
            else if (r == 8)
            begin
                add_unit({LEAD_TAG, 10'($urandom)});
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                add_unit({TRAIL_TAG, 10'($urandom)});
            end
            else
            begin
                add_unit(16'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        unit_valid   = 1'b0;
        code_unit    = '0;
        last_unit    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        units_sent   = 0;
        strings_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, replacement still at its reset value
        // boundaries of the 1, 2 and 3 byte utf-8 length classes
        string_units = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
        send_string(1'b0);
        // lowest and highest supplementary code points
        string_units = '{16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF};
        send_string(1'b0);
        // lead then a plain unit, lone trail, lead then lead, lead at end of string
        string_units = '{16'hD801, 16'h0041, 16'hDC05, 16'hD802, 16'hD803};
        send_string(1'b0);
        // strings of a single bad unit
        string_units = '{16'hD800};
        send_string(1'b0);
        string_units = '{16'hDFFF};
        send_string(1'b0);

        // replacement extremes, a surrogate among them, each against both bad kinds
        write_repl(16'h0000);
        string_units = '{16'hDC00, 16'hD800};
        send_string(1'b0);
        write_repl(16'hFFFF);
        string_units = '{16'hDC00, 16'hD800};
        send_string(1'b0);
        write_repl(16'hDFFF);
        string_units = '{16'hDC00, 16'hD800};
        send_string(1'b0);
        write_repl(16'h0080);
        string_units = '{16'hDC00, 16'hD800};
        send_string(1'b0);

        // random strings, a new replacement every few strings
        while (units_sent < RANDOM_UNITS)
        begin
            if (strings_sent % 5 == 0)
            begin
                write_repl(($urandom_range(0, 3) == 0) ? 16'($urandom) : plain_unit());
            end
            // some strings run with no idling on the sender side, the byte side or both
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            build_random_string();
            send_string(1'b1);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && beats_due == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_lenient_transcoder.sv
sim/utf8_stream_checker.sv
sim/tb.sv
